// File: src/tee_pkg.sv
// Shared types, constants and codes for the timing entropy estimator.
// No dependencies; every other file of the block imports this package.
package tee_pkg;

   // Capacity and derived count width
   localparam int MAX_SAMPLES = 16384;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int OUT_CNT_W   = 15;

   // Histogram geometry
   localparam int NBINS   = 256;
   localparam int BIN_AW  = $clog2(NBINS);
   localparam int NBANKS  = 4;

   // Log2 format: integer exponent over a Q.30 fraction
   localparam int LOG_FRAC = 30;
   localparam int EXP_W    = 5;
   localparam int L_W      = EXP_W + LOG_FRAC;
   localparam int SUM_W    = CNT_W + L_W;

   // Result kinds
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_RAW    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FOLD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELTA  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DDELTA = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATS  = 3'd4;

   // Log operand select
   localparam logic [1:0] LOG_BIN  = 2'd0;
   localparam logic [1:0] LOG_USED = 2'd1;
   localparam logic [1:0] LOG_PEAK = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic              clear_we;
      logic              sample_load;
      logic              sample_upd;
      logic              hist_init;
      logic              bin_chk;
      logic              log_start;
      logic [1:0]        log_sel;
      logic              prod_load;
      logic              acc;
      logic              ln_load;
      logic              div_start;
      logic              div_stats;
      logic              avg_load;
      logic              ent_load;
      logic              emit_hist;
      logic              mean_clear;
      logic              mean_load;
      logic              emit_stats;
      logic [BIN_AW-1:0] idx;
      logic [KIND_W-1:0] kind;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic log_done;
      logic div_done;
      logic bin_zero;
      logic hist_empty;
      logic total_zero;
      logic last;
      logic out_free;
   } status_type;

endpackage

// File: src/tee_log2.sv
// Iterative log2 unit: exponent by leading-one search, fraction by
// repeated squaring, one fraction bit per cycle. Uses tee_pkg.
module tee_log2 import tee_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] x,
   output logic             done,
   output logic [L_W-1:0]   result
);

   localparam int CNT_BITS = $clog2(LOG_FRAC);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [31:0]         m_ff;
   logic [EXP_W-1:0]    exp_ff;
   logic [LOG_FRAC-1:0] frac_ff;

   logic [EXP_W-1:0] lead;
   logic [31:0]      norm;
   logic [63:0]      sq;
   logic [32:0]      sq_top;
   logic             frac_bit;
   logic [31:0]      m_in;

   // leading one and normalised mantissa
   always_comb begin
      lead = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (x[i]) lead = EXP_W'(i);
      end
      norm = 32'(x) << (5'd31 - lead);
   end

   // one squaring step
   assign sq       = m_ff * m_ff;
   assign sq_top   = sq[63:31];
   assign frac_bit = sq_top[32];
   assign m_in     = frac_bit ? sq_top[32:1] : sq_top[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            frac_ff <= '0;
            if (x == '0) begin
               exp_ff  <= '0;
               done_ff <= 1'b1;
            end else begin
               m_ff    <= norm;
               exp_ff  <= lead;
               cnt_ff  <= CNT_BITS'(LOG_FRAC - 1);
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            m_ff    <= m_in;
            frac_ff <= {frac_ff[LOG_FRAC-2:0], frac_bit};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = {exp_ff, frac_ff};

endmodule

// File: src/tee_div.sv
// Restoring divider, 64-bit dividend by a count-wide divisor, one
// quotient bit per cycle. Uses tee_pkg.
module tee_div import tee_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);

   logic             busy_ff;
   logic             done_ff;
   logic [5:0]       cnt_ff;
   logic [63:0]      q_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] d_ff;

   logic [CNT_W:0]   trial;
   logic             fits;
   logic [CNT_W:0]   diff;

   // trial subtract
   assign trial = {rem_ff, q_ff[63]};
   assign fits  = trial >= {1'b0, d_ff};
   assign diff  = trial - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff    <= dividend;
            rem_ff  <= '0;
            d_ff    <= divisor;
            cnt_ff  <= 6'd63;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            q_ff   <= {q_ff[62:0], fits};
            rem_ff <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: src/tee_datapath.sv
// Datapath: four histogram banks, running statistics, log2 and divider
// units, entropy arithmetic and the result register. Uses tee_pkg.
module tee_datapath import tee_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [63:0]          req_sample,
   input  logic                 req_last,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [15:0]          rsp_shannon_bits,
   output logic [15:0]          rsp_min_entropy_bits,
   output logic [OUT_CNT_W-1:0] rsp_peak_count,
   output logic [OUT_CNT_W-1:0] rsp_used_count,
   output logic [63:0]          rsp_low_value,
   output logic [63:0]          rsp_high_value,
   output logic [63:0]          rsp_mean_value,
   output logic                 rsp_overflowed,
   output logic                 rsp_final_item
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

   // rounds Q.30 to Q4.12 and clamps at 8.0
   function automatic logic [15:0] to_q12(input logic [L_W-1:0] v);
      logic [L_W:0]     t;
      logic [L_W-18:0]  r;
      t = {1'b0, v} + (L_W+1)'(1 << 17);
      r = t[L_W:18];
      return (r > (L_W-17)'(32768)) ? 16'd32768 : r[15:0];
   endfunction

   // sample word and running state
   logic [63:0]       sample_ff;
   logic              last_ff;
   logic              ok_ff;
   logic [BIN_AW-1:0] addr_ff [NBANKS];
   logic [BIN_AW-1:0] prior_low_ff;
   logic [BIN_AW-1:0] prior_delta_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [63:0]       low_ff;
   logic [63:0]       high_ff;
   logic [63:0]       sum_ff;
   logic              drop_ff;

   // report walk
   logic [CNT_W-1:0]  bin_ff;
   logic [CNT_W-1:0]  peak_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]  prod_ff;
   logic [L_W-1:0]    ln_ff;
   logic [63:0]       avg_ff;
   logic [15:0]       sh_ff;
   logic [15:0]       me_ff;
   logic [63:0]       mean_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    rsp_kind_ff;
   logic [15:0]          rsp_sh_ff;
   logic [15:0]          rsp_me_ff;
   logic [OUT_CNT_W-1:0] rsp_peak_ff;
   logic [OUT_CNT_W-1:0] rsp_used_ff;
   logic [63:0]          rsp_low_ff;
   logic [63:0]          rsp_high_ff;
   logic [63:0]          rsp_mean_ff;
   logic                 rsp_ovf_ff;
   logic                 rsp_final_ff;

   logic [BIN_AW-1:0] s_lo;
   logic [BIN_AW-1:0] s_fold;
   logic [BIN_AW-1:0] s_d;
   logic [BIN_AW-1:0] s_dd;
   logic [BIN_AW-1:0] new_addr [NBANKS];
   logic              inc_en [NBANKS];
   logic [CNT_W-1:0]  rd_bank [NBANKS];
   logic [CNT_W-1:0]  cur_bin;
   logic [CNT_W-1:0]  used;
   logic [CNT_W-1:0]  log_x;
   logic [63:0]       div_num;
   logic [CNT_W-1:0]  div_den;
   logic              log_done;
   logic [L_W-1:0]    log_res;
   logic              div_done;
   logic [63:0]       div_q;
   logic [63:0]       ln_wide;
   logic [63:0]       sh_diff;
   logic [L_W-1:0]    me_diff;
   logic [63:0]       sum_room;

   // bin addresses of an incoming word
   always_comb begin
      s_lo   = req_sample[7:0];
      s_fold = '0;
      for (int b = 0; b < 8; b++) begin
         s_fold = s_fold ^ req_sample[b*8 +: 8];
      end
      s_d  = s_lo - prior_low_ff;
      s_dd = s_d - prior_delta_ff;
      new_addr[0] = s_lo;
      new_addr[1] = s_fold;
      new_addr[2] = s_d;
      new_addr[3] = s_dd;
   end

   // which banks count this word
   always_comb begin
      inc_en[0] = ok_ff;
      inc_en[1] = ok_ff;
      inc_en[2] = ok_ff && (total_ff >= CNT_W'(1));
      inc_en[3] = ok_ff && (total_ff >= CNT_W'(2));
   end

   // histogram banks: one write and one registered read a cycle
   for (genvar g = 0; g < NBANKS; g++) begin : g_bank
      logic [CNT_W-1:0]  mem [NBINS];
      logic [CNT_W-1:0]  rd_ff;
      logic              we;
      logic [BIN_AW-1:0] waddr;
      logic [CNT_W-1:0]  wdata;
      logic [BIN_AW-1:0] raddr;

      always_comb begin
         we    = 1'b0;
         waddr = cmd.idx;
         wdata = '0;
         priority if (cmd.clear_we) begin
            we = 1'b1;
         end else if (cmd.bin_chk && cmd.kind == KIND_W'(g)) begin
            we = 1'b1;
         end else if (cmd.sample_upd && inc_en[g]) begin
            we    = 1'b1;
            waddr = addr_ff[g];
            wdata = rd_ff + 1'b1;
         end
         raddr = cmd.sample_load ? new_addr[g] : cmd.idx;
      end

      always_ff @(posedge clock) begin
         if (we) mem[waddr] <= wdata;
         rd_ff <= mem[raddr];
      end

      assign rd_bank[g] = rd_ff;
   end

   assign cur_bin = rd_bank[cmd.kind[1:0]];

   // entries counted per histogram
   always_comb begin
      priority if (cmd.kind == KIND_DELTA) begin
         used = (total_ff >= CNT_W'(1)) ? total_ff - CNT_W'(1) : '0;
      end else if (cmd.kind == KIND_DDELTA) begin
         used = (total_ff >= CNT_W'(2)) ? total_ff - CNT_W'(2) : '0;
      end else begin
         used = total_ff;
      end
   end

   // unit operands
   always_comb begin
      case (cmd.log_sel)
         LOG_BIN:  log_x = cur_bin;
         LOG_USED: log_x = used;
         LOG_PEAK: log_x = peak_ff;
         default:  log_x = '0;
      endcase
      div_num = cmd.div_stats ? sum_ff : 64'(acc_ff);
      div_den = cmd.div_stats ? total_ff : used;
   end

   tee_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   tee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // entropy differences
   assign ln_wide  = 64'(ln_ff);
   assign sh_diff  = ln_wide - avg_ff;
   assign me_diff  = ln_ff - log_res;
   assign sum_room = ~sum_ff;

   // control state and running statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_low_ff   <= '0;
         prior_delta_ff <= '0;
         total_ff       <= '0;
         low_ff         <= '1;
         high_ff        <= '0;
         sum_ff         <= '0;
         drop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.sample_upd) begin
            if (ok_ff) begin
               prior_low_ff <= addr_ff[0];
               if (total_ff >= CNT_W'(1)) prior_delta_ff <= addr_ff[2];
               if (sample_ff < low_ff) low_ff <= sample_ff;
               if (sample_ff > high_ff) high_ff <= sample_ff;
               if (sample_ff > sum_room) begin
                  sum_ff  <= '1;
                  drop_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_ff + sample_ff;
               end
               total_ff <= total_ff + 1'b1;
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (cmd.emit_stats) begin
            prior_low_ff   <= '0;
            prior_delta_ff <= '0;
            total_ff       <= '0;
            low_ff         <= '1;
            high_ff        <= '0;
            sum_ff         <= '0;
            drop_ff        <= 1'b0;
         end
         if (cmd.emit_hist || cmd.emit_stats) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                  rsp_valid_ff <= 1'b0;
      end
   end

   // word capture and report arithmetic
   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         sample_ff <= req_sample;
         last_ff   <= req_last;
         ok_ff     <= total_ff < MAX_CNT;
         for (int k = 0; k < NBANKS; k++) addr_ff[k] <= new_addr[k];
      end
      if (cmd.hist_init) begin
         acc_ff  <= '0;
         peak_ff <= '0;
         sh_ff   <= '0;
         me_ff   <= '0;
      end
      if (cmd.bin_chk) begin
         bin_ff <= cur_bin;
         if (cur_bin > peak_ff) peak_ff <= cur_bin;
      end
      if (cmd.prod_load) prod_ff <= bin_ff * log_res;
      if (cmd.acc)       acc_ff  <= acc_ff + prod_ff;
      if (cmd.ln_load)   ln_ff   <= log_res;
      if (cmd.avg_load)  avg_ff  <= div_q;
      if (cmd.ent_load) begin
         sh_ff <= (ln_wide > avg_ff) ? to_q12(sh_diff[L_W-1:0]) : 16'd0;
         me_ff <= (ln_ff > log_res) ? to_q12(me_diff) : 16'd0;
      end
      if (cmd.mean_clear) mean_ff <= '0;
      if (cmd.mean_load)  mean_ff <= div_q;
      if (cmd.emit_hist) begin
         rsp_kind_ff  <= cmd.kind;
         rsp_sh_ff    <= sh_ff;
         rsp_me_ff    <= me_ff;
         rsp_peak_ff  <= peak_ff[OUT_CNT_W-1:0];
         rsp_used_ff  <= used[OUT_CNT_W-1:0];
         rsp_low_ff   <= '0;
         rsp_high_ff  <= '0;
         rsp_mean_ff  <= '0;
         rsp_ovf_ff   <= drop_ff;
         rsp_final_ff <= 1'b0;
      end
      if (cmd.emit_stats) begin
         rsp_kind_ff  <= KIND_STATS;
         rsp_sh_ff    <= '0;
         rsp_me_ff    <= '0;
         rsp_peak_ff  <= '0;
         rsp_used_ff  <= total_ff[OUT_CNT_W-1:0];
         rsp_low_ff   <= low_ff;
         rsp_high_ff  <= high_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_ovf_ff   <= drop_ff;
         rsp_final_ff <= 1'b1;
      end
   end

   // status back to the controller
   always_comb begin
      status.log_done   = log_done;
      status.div_done   = div_done;
      status.bin_zero   = cur_bin == '0;
      status.hist_empty = (peak_ff == '0) || (used == '0);
      status.total_zero = total_ff == '0;
      status.last       = last_ff;
      status.out_free   = !rsp_valid_ff;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_shannon_bits     = rsp_sh_ff;
   assign rsp_min_entropy_bits = rsp_me_ff;
   assign rsp_peak_count       = rsp_peak_ff;
   assign rsp_used_count       = rsp_used_ff;
   assign rsp_low_value        = rsp_low_ff;
   assign rsp_high_value       = rsp_high_ff;
   assign rsp_mean_value       = rsp_mean_ff;
   assign rsp_overflowed       = rsp_ovf_ff;
   assign rsp_final_item       = rsp_final_ff;

endmodule

// File: src/tee_ctrl.sv
// Controller: sequences bank clearing, sample updates and the report walk.
// Uses tee_pkg for the command and status structs.
module tee_ctrl import tee_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_UPD    = 4'd2;
   localparam logic [3:0] S_HSTART = 4'd3;
   localparam logic [3:0] S_RD     = 4'd4;
   localparam logic [3:0] S_CHK    = 4'd5;
   localparam logic [3:0] S_BLOG   = 4'd6;
   localparam logic [3:0] S_ACC    = 4'd7;
   localparam logic [3:0] S_LN     = 4'd8;
   localparam logic [3:0] S_LNW    = 4'd9;
   localparam logic [3:0] S_DIVW   = 4'd10;
   localparam logic [3:0] S_PKW    = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;
   localparam logic [3:0] S_SSTART = 4'd13;
   localparam logic [3:0] S_SDIVW  = 4'd14;
   localparam logic [3:0] S_SEMIT  = 4'd15;

   localparam logic [BIN_AW-1:0] IDX_LAST = BIN_AW'(NBINS - 1);

   logic [3:0]        state_ff, state_in;
   logic [BIN_AW-1:0] idx_ff, idx_in;
   logic [KIND_W-1:0] kind_ff, kind_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.idx   = idx_ff;
      cmd.kind  = kind_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.sample_load = 1'b1;
               state_in        = S_UPD;
            end
         end
         S_UPD: begin
            cmd.sample_upd = 1'b1;
            if (status.last) begin
               kind_in  = KIND_RAW;
               state_in = S_HSTART;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_HSTART: begin
            cmd.hist_init = 1'b1;
            idx_in        = '0;
            state_in      = S_RD;
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.bin_chk = 1'b1;
            if (!status.bin_zero) begin
               cmd.log_start = 1'b1;
               cmd.log_sel   = LOG_BIN;
               state_in      = S_BLOG;
            end else if (idx_ff == IDX_LAST) begin
               state_in = S_LN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_BLOG: begin
            if (status.log_done) begin
               cmd.prod_load = 1'b1;
               state_in      = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = S_LN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_LN: begin
            if (status.hist_empty) begin
               state_in = S_EMIT;
            end else begin
               cmd.log_start = 1'b1;
               cmd.log_sel   = LOG_USED;
               state_in      = S_LNW;
            end
         end
         S_LNW: begin
            if (status.log_done) begin
               cmd.ln_load   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIVW;
            end
         end
         S_DIVW: begin
            if (status.div_done) begin
               cmd.avg_load  = 1'b1;
               cmd.log_start = 1'b1;
               cmd.log_sel   = LOG_PEAK;
               state_in      = S_PKW;
            end
         end
         S_PKW: begin
            if (status.log_done) begin
               cmd.ent_load = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_hist = 1'b1;
               if (kind_ff == KIND_DDELTA) begin
                  state_in = S_SSTART;
               end else begin
                  kind_in  = kind_ff + 1'b1;
                  state_in = S_HSTART;
               end
            end
         end
         S_SSTART: begin
            cmd.mean_clear = 1'b1;
            if (status.total_zero) begin
               state_in = S_SEMIT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_stats = 1'b1;
               state_in      = S_SDIVW;
            end
         end
         S_SDIVW: begin
            if (status.div_done) begin
               cmd.mean_load = 1'b1;
               state_in      = S_SEMIT;
            end
         end
         S_SEMIT: begin
            if (status.out_free) begin
               cmd.emit_stats = 1'b1;
               state_in       = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         kind_ff  <= KIND_RAW;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// File: src/timing_entropy_estimator.sv
// Timing entropy estimator. A sample word takes a bank read, then an
// increment write; the next word is taken once the update is written.
// A word marked last starts a report walk of 256 bins per histogram, one
// log2 per non-empty bin, then a log2, a division and a log2 per
// non-empty histogram and a division for the mean; the log2 and divider
// units set the report length. Reset clears every bin of the banks.
module timing_entropy_estimator import tee_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [63:0]          req_sample,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [15:0]          rsp_shannon_bits,
   output logic [15:0]          rsp_min_entropy_bits,
   output logic [OUT_CNT_W-1:0] rsp_peak_count,
   output logic [OUT_CNT_W-1:0] rsp_used_count,
   output logic [63:0]          rsp_low_value,
   output logic [63:0]          rsp_high_value,
   output logic [63:0]          rsp_mean_value,
   output logic                 rsp_overflowed,
   output logic                 rsp_final_item
);

   cmd_type    cmd;
   status_type status;

   tee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tee_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_sample           (req_sample),
      .req_last             (req_last),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_shannon_bits     (rsp_shannon_bits),
      .rsp_min_entropy_bits (rsp_min_entropy_bits),
      .rsp_peak_count       (rsp_peak_count),
      .rsp_used_count       (rsp_used_count),
      .rsp_low_value        (rsp_low_value),
      .rsp_high_value       (rsp_high_value),
      .rsp_mean_value       (rsp_mean_value),
      .rsp_overflowed       (rsp_overflowed),
      .rsp_final_item       (rsp_final_item)
   );

endmodule

// File: src/tee_checker.sv
// Port-level checks on the result channel of the estimator, with the bind
// that attaches them to the top level. Uses tee_pkg for the kind codes.
module tee_checker import tee_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [KIND_W-1:0]    rsp_kind,
   input logic [OUT_CNT_W-1:0] rsp_peak_count,
   input logic [OUT_CNT_W-1:0] rsp_used_count,
   input logic [63:0]          rsp_low_value,
   input logic [63:0]          rsp_high_value,
   input logic                 rsp_final_item
);

   // a stalled word stays valid and keeps its kind
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result word changed while stalled");

   // only the stats word closes a report
   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_item == (rsp_kind == KIND_STATS)))
      else $error("final flag does not match stats kind");

   // a bin never holds more than the histogram counted
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_STATS |-> rsp_peak_count <= rsp_used_count)
      else $error("peak count above used count");

   // with samples present the minimum does not exceed the maximum
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATS && rsp_used_count != '0
      |-> rsp_low_value <= rsp_high_value)
      else $error("minimum above maximum");

endmodule

bind timing_entropy_estimator tee_checker u_tee_checker (.*);
